// File: design/mms_pkg.sv
package mms_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned CountW  = 7;
  localparam int unsigned StatusW = 2;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic    push;
    logic    pop;
    logic    fault;
    status_e fault_code;
    logic    top;
    logic    step;
  } mms_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic scan_more;
    logic out_busy;
  } mms_stat_t;

endpackage

// File: design/min_max_stack.sv
// Min/max stack: a LIFO of signed 32-bit words that reports the least and
// greatest held value with every result word. Input tuser selects push (0) or
// pop (1); each input word yields exactly one output word. A push, an
// overflowing push and an underflowing pop load the result register in the
// cycle they are accepted. A successful pop holds the input off through the
// TOP and SCAN states: the stack memory has one read port, so the top is read
// first and then the remaining entries are rescanned one per cycle to rebuild
// min and max. When the stack empties, min and max keep the word just popped.
// The input is held off while a result word waits in the output register; it
// is taken again in the cycle that word is taken, or once the register is empty.
module min_max_stack #(
  parameter int unsigned DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // [31:0] value
  input  logic [0:0]   s_axis_tuser,   // [0] action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // popped_value, least_value, greatest_value,
                                       // entry_count, zero pad
  output logic [1:0]   m_axis_tuser    // [1:0] status
);
  import mms_pkg::*;

  mms_cmd_t  cmd;
  mms_stat_t stat;
  status_e   out_status;
  logic signed [DataW-1:0] out_popped, out_least, out_greatest;
  logic [CountW-1:0] out_count;

  mms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (action_e'(s_axis_tuser[0])),
    .stat_i      (stat),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd)
  );

  mms_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .in_value_i     (s_axis_tdata),
    .out_ready_i    (m_axis_tready),
    .stat_o         (stat),
    .out_valid_o    (m_axis_tvalid),
    .out_status_o   (out_status),
    .out_popped_o   (out_popped),
    .out_least_o    (out_least),
    .out_greatest_o (out_greatest),
    .out_count_o    (out_count)
  );

  assign m_axis_tdata = {1'b0, out_count, out_greatest, out_least, out_popped};
  assign m_axis_tuser = out_status;

endmodule

// File: design/mms_ctrl.sv
module mms_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  mms_pkg::action_e   in_action_i,
  input  mms_pkg::mms_stat_t stat_i,
  output logic               in_ready_o,
  output mms_pkg::mms_cmd_t  cmd_o
);
  import mms_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TOP  = 3'b010,
    S_SCAN = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE) && !stat_i.out_busy;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.fault_code = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_action_i == ACT_PUSH) begin
            if (stat_i.full) begin
              cmd_o.fault      = 1'b1;
              cmd_o.fault_code = ST_OVERFLOW;
            end else begin
              cmd_o.push = 1'b1;
            end
          end else begin
            if (stat_i.empty) begin
              cmd_o.fault      = 1'b1;
              cmd_o.fault_code = ST_UNDERFLOW;
            end else begin
              cmd_o.pop = 1'b1;
              state_d   = S_TOP;
            end
          end
        end
      end
      S_TOP: begin
        cmd_o.top = 1'b1;
        state_d   = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        if (!stat_i.scan_more) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/mms_dp.sv
module mms_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mms_pkg::mms_cmd_t                   cmd_i,
  input  logic signed [mms_pkg::DataW-1:0]    in_value_i,
  input  logic                                out_ready_i,
  output mms_pkg::mms_stat_t                  stat_o,
  output logic                                out_valid_o,
  output mms_pkg::status_e                    out_status_o,
  output logic signed [mms_pkg::DataW-1:0]    out_popped_o,
  output logic signed [mms_pkg::DataW-1:0]    out_least_o,
  output logic signed [mms_pkg::DataW-1:0]    out_greatest_o,
  output logic        [mms_pkg::CountW-1:0]   out_count_o
);
  import mms_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [DataW-1:0] mem [DEPTH];
  logic signed [DataW-1:0] rd_data_q;
  logic        [AW-1:0]    rd_addr;

  logic [CW-1:0] fill_q, fill_d, fill_dec;
  logic [CW-1:0] idx_q, idx_d;
  logic          first_q;
  logic signed [DataW-1:0] min_q, min_d, max_q, max_d;
  logic signed [DataW-1:0] popped_q;
  logic signed [DataW-1:0] lo_in, hi_in, lo_new, hi_new;

  logic          load, finish, out_valid_q;
  status_e       status_q;
  logic signed [DataW-1:0] popped_out_q, least_q, greatest_q;
  logic [CountW-1:0] count_q;
  logic [CW+CountW-1:0] count_ext;

  assign fill_dec          = fill_q - CW'(1);
  assign stat_o.full       = (fill_q == CW'(DEPTH));
  assign stat_o.empty      = (fill_q == '0);
  assign stat_o.scan_more  = (idx_q < fill_q);
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;

  always_comb begin
    if (cmd_i.pop) begin
      rd_addr = fill_dec[AW-1:0];
    end else if (cmd_i.top) begin
      rd_addr = '0;
    end else begin
      rd_addr = idx_q[AW-1:0];
    end
  end

  // stack memory, single write and single registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[fill_q[AW-1:0]] <= in_value_i;
    end
    rd_data_q <= mem[rd_addr];
  end

  // rescan fold, first word seeds both bounds
  assign lo_in  = first_q ? rd_data_q : min_q;
  assign hi_in  = first_q ? rd_data_q : max_q;
  assign lo_new = (rd_data_q < lo_in) ? rd_data_q : lo_in;
  assign hi_new = (hi_in < rd_data_q) ? rd_data_q : hi_in;

  always_comb begin
    fill_d = fill_q;
    min_d  = min_q;
    max_d  = max_q;
    idx_d  = idx_q;
    if (cmd_i.push) begin
      fill_d = fill_q + CW'(1);
      if (fill_q == '0) begin
        min_d = in_value_i;
        max_d = in_value_i;
      end else if (in_value_i < min_q) begin
        min_d = in_value_i;
      end else if (max_q < in_value_i) begin
        max_d = in_value_i;
      end
    end
    if (cmd_i.pop) begin
      fill_d = fill_dec;
    end
    if (cmd_i.top) begin
      idx_d = CW'(1);
    end
    if (cmd_i.step) begin
      min_d = lo_new;
      max_d = hi_new;
      if (stat_o.scan_more) begin
        idx_d = idx_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      min_q  <= '0;
      max_q  <= '0;
    end else begin
      fill_q <= fill_d;
      min_q  <= min_d;
      max_q  <= max_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.top) begin
      popped_q <= rd_data_q;
      first_q  <= 1'b1;
    end else if (cmd_i.step) begin
      first_q  <= 1'b0;
    end
  end

  // output word register
  assign finish    = cmd_i.step && !stat_o.scan_more;
  assign load      = cmd_i.push || cmd_i.fault || finish;
  assign count_ext = (CW+CountW)'(fill_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q     <= cmd_i.fault ? cmd_i.fault_code : ST_OK;
      popped_out_q <= finish ? popped_q : '0;
      least_q      <= min_d;
      greatest_q   <= max_d;
      count_q      <= count_ext[CountW-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_status_o   = status_q;
  assign out_popped_o   = popped_out_q;
  assign out_least_o    = least_q;
  assign out_greatest_o = greatest_q;
  assign out_count_o    = count_q;

endmodule

// File: tb/tb_min_max_stack.sv
`timescale 1ns / 1ps

module tb_min_max_stack;
  import mms_pkg::*;

  localparam int Depth = 64;
  localparam logic signed [31:0] MaxVal = 32'sh7fff_ffff;
  localparam logic signed [31:0] MinVal = 32'sh8000_0000;

  typedef struct {
    status_e           status;
    logic signed [31:0] popped;
    logic signed [31:0] least;
    logic signed [31:0] greatest;
    logic [6:0]         count;
  } stack_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;   // [31:0] value
  logic [0:0]   s_axis_tuser = '0;   // [0] action
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;        // popped, least, greatest, count, pad
  logic [1:0]   m_axis_tuser;        // [1:0] status

  min_max_stack #(.DEPTH(Depth)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // shadow stack
  logic signed [31:0] shadow_mem [Depth];
  int                 shadow_fill = 0;
  logic signed [31:0] shadow_lo = '0;
  logic signed [31:0] shadow_hi = '0;

  stack_result_t pending_results[$];
  int unsigned   n_errors = 0;
  int unsigned   n_checked = 0;
  int unsigned   n_push = 0, n_pop = 0, n_overflow = 0, n_underflow = 0;
  int            peak_fill = 0;
  bit            tx_steady = 1'b0;
  bit            rx_steady = 1'b0;
  int unsigned   hold_cycles = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 4))
        0: return MinVal;
        1: return MaxVal;
        2: return 32'sd0;
        3: return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    if (r < 40) return $signed(32'($urandom_range(0, 16))) - 32'sd8;
    return $urandom;
  endfunction

  function automatic void stack_predict(input action_e act, input logic signed [31:0] val,
                                        output stack_result_t res);
    res.status = ST_OK;
    res.popped = '0;
    if (act == ACT_PUSH) begin
      if (shadow_fill >= Depth) begin
        res.status = ST_OVERFLOW;
        n_overflow++;
      end else begin
        shadow_mem[shadow_fill] = val;
        if (shadow_fill == 0) begin
          shadow_lo = val;
          shadow_hi = val;
        end else if (val < shadow_lo) begin
          shadow_lo = val;
        end else if (val > shadow_hi) begin
          shadow_hi = val;
        end
        shadow_fill++;
        n_push++;
        if (shadow_fill > peak_fill) peak_fill = shadow_fill;
      end
    end else if (shadow_fill == 0) begin
      res.status = ST_UNDERFLOW;
      n_underflow++;
    end else begin
      shadow_fill--;
      res.popped = shadow_mem[shadow_fill];
      // empty stack keeps the bottom word just removed
      shadow_lo = shadow_mem[0];
      shadow_hi = shadow_mem[0];
      for (int i = 0; i < shadow_fill; i++) begin
        if (shadow_mem[i] < shadow_lo) shadow_lo = shadow_mem[i];
        if (shadow_mem[i] > shadow_hi) shadow_hi = shadow_mem[i];
      end
      n_pop++;
    end
    res.least    = shadow_lo;
    res.greatest = shadow_hi;
    res.count    = 7'(shadow_fill);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    if (n_errors < 20)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, got_v);
    n_errors++;
  endtask

  // one word per call; valid stays high when no gap follows
  task automatic send_word(input action_e act, input logic signed [31:0] val);
    stack_result_t res;
    int unsigned   gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    stack_predict(act, val, res);
    pending_results.push_back(res);
    gap = tx_steady ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Depth + 4) @(posedge clk_i);
  endtask

  // receiver
  initial begin : receiver
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
        m_axis_tready <= 1'b1;
      end else if (rx_steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    stack_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", 32'd0, 32'(m_axis_tuser));
      end else begin
        exp_r = pending_results.pop_front();
        n_checked++;
        if (m_axis_tuser !== exp_r.status)
          report_mismatch("status", 32'(exp_r.status), 32'(m_axis_tuser));
        if (m_axis_tdata[31:0] !== exp_r.popped)
          report_mismatch("popped", exp_r.popped, m_axis_tdata[31:0]);
        if (m_axis_tdata[63:32] !== exp_r.least)
          report_mismatch("least", exp_r.least, m_axis_tdata[63:32]);
        if (m_axis_tdata[95:64] !== exp_r.greatest)
          report_mismatch("greatest", exp_r.greatest, m_axis_tdata[95:64]);
        if (m_axis_tdata[102:96] !== exp_r.count)
          report_mismatch("count", 32'(exp_r.count), 32'(m_axis_tdata[102:96]));
      end
    end
  end

  task automatic test_corner_values();
    send_word(ACT_POP, 32'sd0);      // underflow straight after reset
    send_word(ACT_PUSH, -32'sd5);
    send_word(ACT_PUSH, MaxVal);
    send_word(ACT_PUSH, MinVal);
    send_word(ACT_PUSH, 32'sd0);
    send_word(ACT_PUSH, -32'sd1);
    send_word(ACT_PUSH, MinVal);
    send_word(ACT_POP, MaxVal);
    send_word(ACT_POP, 32'sd0);
    send_word(ACT_POP, 32'sd0);
    send_word(ACT_POP, 32'sd0);
    send_word(ACT_POP, 32'sd0);
    send_word(ACT_POP, 32'sd0);      // empties: bounds keep bottom word
    send_word(ACT_POP, -32'sd1);     // underflow with stale bounds
    send_word(ACT_PUSH, MaxVal);
    send_word(ACT_PUSH, MaxVal);
    send_word(ACT_POP, 32'sd0);
    send_word(ACT_POP, 32'sd0);
  endtask

  task automatic test_full_stack();
    while (shadow_fill < Depth) send_word(ACT_PUSH, pick_value());
    repeat (3) send_word(ACT_PUSH, pick_value());
    send_word(ACT_POP, 32'sd0);
    send_word(ACT_PUSH, MinVal);
    send_word(ACT_PUSH, MaxVal);
    while (shadow_fill > 0) send_word(ACT_POP, pick_value());
    send_word(ACT_POP, 32'sd0);
  endtask

  task automatic test_random_mix(input int unsigned n_words);
    int unsigned push_pct;
    int unsigned left;
    left = n_words;
    while (left != 0) begin
      case ($urandom_range(0, 5))
        0: push_pct = 15;
        1: push_pct = 40;
        2: push_pct = 50;
        3: push_pct = 60;
        4: push_pct = 85;
        default: push_pct = 97;
      endcase
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      repeat (25) begin
        if (left != 0) begin
          if ($urandom_range(0, 99) < push_pct) send_word(ACT_PUSH, pick_value());
          else send_word(ACT_POP, pick_value());
          left--;
        end
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_output_stall();
    hold_cycles = 400;
    tx_steady = 1'b1;
    repeat (12) send_word(ACT_PUSH, pick_value());
    repeat (8) send_word(ACT_POP, pick_value());
    tx_steady = 1'b0;
  endtask

  task automatic test_drain_pause();
    wait_drained();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (20) begin
      if ($urandom_range(0, 1) == 0) send_word(ACT_PUSH, pick_value());
      else send_word(ACT_POP, pick_value());
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_values();
    test_full_stack();
    test_random_mix(100);
    test_output_stall();
    test_drain_pause();
    test_random_mix(100);
    wait_drained();
    $display("checked %0d words: %0d pushes, %0d pops, %0d overflows, %0d underflows",
             n_checked, n_push, n_pop, n_overflow, n_underflow);
    $display("peak depth %0d of %0d, with stalls on both sides", peak_fill, Depth);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
